// ===== rtl/dtnp_pkg.sv =====
`timescale 1ns / 1ps

package dtnp_pkg;

    // Accumulator width and limit on digits after the point.
    localparam int MANTISSA_BITS       = 32;
    localparam int MAX_FRACTION_DIGITS = 6;

    // Widths of the transaction fields.
    localparam int TEXT_W     = 8;
    localparam int MANT_OUT_W = 32;
    localparam int FRAC_W     = 3;
    localparam int DIGIT_W    = 4;

    // Characters that the parser recognises.
    localparam logic [TEXT_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [TEXT_W-1:0] CHAR_COMMA = 8'h2C;

    // Largest value that the accumulator can hold.
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = {MANTISSA_BITS{1'b1}};

    // Accumulator together with its saturation flag.
    typedef struct packed {
        logic [MANTISSA_BITS-1:0] acc;
        logic                     sat;
    } acc_state_t;

endpackage

// ===== rtl/decimal_text_number_parser_top.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | text_byte[7:0]
// output   | out_valid / out_ready  | mantissa[31:0], fraction_digits[2:0],
//          |                        | digit_seen, overflowed
//
// One byte is taken in every cycle while in_ready is high; a zero byte's result is
// registered in the output register, or in the skid entry if the output is held.
// The digit update (multiply by ten and add) lies within the parse state update.
// Reset clears the parse state and empties the output and skid registers.
// A two-entry output stage lets bytes flow while one result waits; in_ready
// drops only when both entries are full.

module decimal_text_number_parser_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dtnp_pkg::TEXT_W-1:0]         text_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dtnp_pkg::MANT_OUT_W-1:0]     mantissa,
    output logic [dtnp_pkg::FRAC_W-1:0]         fraction_digits,
    output logic                                digit_seen,
    output logic                                overflowed
);
    import dtnp_pkg::*;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MANT_OUT_W-1:0] mant;
        logic [FRAC_W-1:0]     frac;
        logic                  seen;
        logic                  ovf;
    } result_t;

    localparam int EXT_W = (MANTISSA_BITS > MANT_OUT_W) ? MANTISSA_BITS : MANT_OUT_W;

    phase_t            phase_reg, phase_next;
    acc_state_t        acc_reg, acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;

    result_t out_reg, skid_reg, new_result;
    logic    out_valid_reg, skid_valid_reg;

    logic              accept;
    logic              is_digit;
    logic              is_sep;
    logic              is_end;
    logic [DIGIT_W-1:0] digit;
    acc_state_t        pushed;
    logic [EXT_W-1:0]  acc_ext;
    logic              load_out;

    // Character classification.
    assign accept   = in_valid && in_ready;
    assign is_end   = (text_byte == CHAR_NUL);
    assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_sep   = (text_byte == CHAR_DOT) || (text_byte == CHAR_COMMA);
    assign digit    = DIGIT_W'(text_byte - CHAR_ZERO);

    dtnp_digit_acc u_digit_acc (
        .cur   (acc_reg),
        .digit (digit),
        .nxt   (pushed)
    );

    // Result formed from the state before the end-of-line byte.
    assign acc_ext = EXT_W'(acc_reg.acc);
    always_comb
    begin
        new_result.mant = acc_ext[MANT_OUT_W-1:0];
        new_result.frac = frac_reg;
        new_result.seen = (phase_reg != PH_SEEK);
        new_result.ovf  = acc_reg.sat;
    end

    // Parse state update for one byte.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        if (is_end)
        begin
            phase_next = PH_SEEK;
            acc_next   = '0;
            frac_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if (is_digit)
                    begin
                        acc_next   = pushed;
                        phase_next = PH_INT;
                    end
                end
                PH_INT:
                begin
                    if (is_digit)
                        acc_next = pushed;
                    else if (is_sep)
                        phase_next = PH_FRAC;
                    else
                        phase_next = PH_DONE;
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (32'(frac_reg) < MAX_FRACTION_DIGITS)
                        begin
                            acc_next  = pushed;
                            frac_next = frac_reg + FRAC_W'(1);
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            acc_reg   <= '0;
            frac_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
        end
    end

    // Output register with a skid entry behind it.
    assign load_out = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept && is_end;
            end
            else
            begin
                out_valid_reg <= accept && is_end;
            end
        end
        else if (accept && is_end)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
        else if (accept && is_end)
        begin
            skid_reg <= new_result;
        end
    end

    assign in_ready        = !skid_valid_reg;
    assign out_valid       = out_valid_reg;
    assign mantissa        = out_reg.mant;
    assign fraction_digits = out_reg.frac;
    assign digit_seen      = out_reg.seen;
    assign overflowed      = out_reg.ovf;

`ifndef NO_ASSERTIONS
    // The skid entry is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register is empty");

    // A line with no digit reports a zero value.
    a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !digit_seen) |->
            (mantissa == '0 && fraction_digits == '0 && !overflowed))
        else $error("result without digits carries a value");

    // A saturated mantissa shows all ones.
    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflowed) |-> (mantissa == {MANT_OUT_W{1'b1}}))
        else $error("overflowed result not at maximum");

    // Fraction digit count never passes its limit.
    a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(frac_reg) <= MAX_FRACTION_DIGITS)
        else $error("fraction digit count beyond limit");
`endif

endmodule

// ===== rtl/dtnp_digit_acc.sv =====
`timescale 1ns / 1ps

module dtnp_digit_acc (
    input  dtnp_pkg::acc_state_t             cur,
    input  logic [dtnp_pkg::DIGIT_W-1:0]     digit,
    output dtnp_pkg::acc_state_t             nxt
);
    import dtnp_pkg::*;

    localparam int PROD_W = MANTISSA_BITS + 4;

    logic [PROD_W-1:0] acc_ext;
    logic [PROD_W-1:0] scaled;
    logic              too_big;

    // Multiply by ten as two shifted copies, then add the new digit.
    assign acc_ext = PROD_W'(cur.acc);
    assign scaled  = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(digit);
    assign too_big = (scaled > PROD_W'(MANT_MAX));

    // Once saturated, the accumulator holds at its maximum.
    always_comb
    begin
        if (cur.sat || too_big)
        begin
            nxt.acc = MANT_MAX;
            nxt.sat = 1'b1;
        end
        else
        begin
            nxt.acc = scaled[MANTISSA_BITS-1:0];
            nxt.sat = 1'b0;
        end
    end

endmodule

// ===== tb/decimal_text_number_parser_top_test.sv =====
`timescale 1ns / 1ps

module decimal_text_number_parser_top_test;

    import dtnp_pkg::*;

    // Where the parser stands within the current line.
    typedef enum logic [1:0] {
        SEEK_DIGIT,
        INTEGER_PART,
        FRACTION_PART,
        NUMBER_ENDED
    } line_phase_e;

    // One character to send, with its idle time ahead of it. A hold entry
    // carries no character: the sender waits until every number has come back.
    typedef struct {
        logic [TEXT_W-1:0] ch;
        int unsigned       gap;
        bit                hold;
    } text_item_t;

    // One parsed number as the block should report it.
    typedef struct {
        logic [MANT_OUT_W-1:0] mant;
        logic [FRAC_W-1:0]     frac;
        logic                  seen;
        logic                  ovf;
    } parsed_number_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TEXT_W-1:0]     text_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MANT_OUT_W-1:0] mantissa;
    logic [FRAC_W-1:0]     fraction_digits;
    logic                  digit_seen;
    logic                  overflowed;

    text_item_t     pending_chars[$];
    parsed_number_t expected_numbers[$];

    // Shadow copy of the parse state.
    line_phase_e              line_phase = SEEK_DIGIT;
    logic [MANTISSA_BITS-1:0] value_acc = '0;
    logic [FRAC_W-1:0]        frac_count = '0;
    logic                     value_saturated = 1'b0;

    int unsigned gap_left = 0;
    bit          draining = 1'b0;
    int unsigned stall_left = 0;
    int unsigned steady_left = 0;
    int unsigned error_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned numbers_checked = 0;
    int unsigned saturated_numbers = 0;
    int unsigned fraction_numbers = 0;

    decimal_text_number_parser_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mantissa        (mantissa),
        .fraction_digits (fraction_digits),
        .digit_seen      (digit_seen),
        .overflowed      (overflowed)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Any non-zero character that is not a digit.
    function automatic logic [TEXT_W-1:0] random_non_digit();
        logic [TEXT_W-1:0] ch;
        do
            ch = TEXT_W'($urandom_range(1, 255));
        while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
        return ch;
    endfunction

    function automatic logic [TEXT_W-1:0] random_digit();
        return CHAR_ZERO + TEXT_W'($urandom_range(0, 9));
    endfunction

    task automatic queue_char(input logic [TEXT_W-1:0] ch, input bit steady);
        text_item_t item;
        item.ch   = ch;
        item.gap  = steady ? 0 : idle_length();
        item.hold = 1'b0;
        pending_chars.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], 1'b0);
    endtask

    // Append one digit to the shadow accumulator, holding at the maximum.
    function automatic void append_digit(input logic [3:0] digit);
        logic [MANTISSA_BITS+3:0] widened;
        widened = {4'b0, value_acc} * (MANTISSA_BITS + 4)'(10) + digit;
        if (value_saturated || widened > {4'b0, MANT_MAX})
        begin
            value_acc       = MANT_MAX;
            value_saturated = 1'b1;
        end
        else
            value_acc = widened[MANTISSA_BITS-1:0];
    endfunction

    // Advance the shadow parser by one character; a line end yields a number.
    function automatic void parse_text_char(input logic [TEXT_W-1:0] ch);
        logic           is_digit;
        parsed_number_t number;
        is_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
        if (ch == CHAR_NUL)
        begin
            number.mant = MANT_OUT_W'(value_acc);
            number.frac = frac_count;
            number.seen = (line_phase != SEEK_DIGIT);
            number.ovf  = value_saturated;
            expected_numbers.push_back(number);
            line_phase      = SEEK_DIGIT;
            value_acc       = '0;
            frac_count      = '0;
            value_saturated = 1'b0;
            return;
        end
        case (line_phase)
            SEEK_DIGIT:
                if (is_digit)
                begin
                    append_digit(ch[3:0]);
                    line_phase = INTEGER_PART;
                end
            INTEGER_PART:
                if (is_digit)
                    append_digit(ch[3:0]);
                else if (ch == CHAR_DOT || ch == CHAR_COMMA)
                    line_phase = FRACTION_PART;
                else
                    line_phase = NUMBER_ENDED;
            FRACTION_PART:
                if (is_digit)
                begin
                    // Digits past the limit are dropped but keep the number open.
                    if (frac_count < MAX_FRACTION_DIGITS)
                    begin
                        append_digit(ch[3:0]);
                        frac_count = frac_count + 1'b1;
                    end
                end
                else
                    line_phase = NUMBER_ENDED;
            default:
                ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Input driver: offers queued characters, honouring gaps and hold points.
    always @(posedge clk or negedge rst_n)
    begin
        text_item_t item;
        logic       next_valid;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            text_byte <= '0;
            gap_left  = 0;
            draining  = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_text_char(text_byte);
                bytes_accepted++;
            end
            // A transaction still on offer stays put until it is taken.
            if (!(in_valid && !in_ready))
            begin
                next_valid = 1'b0;
                if (draining && expected_numbers.size() == 0)
                    draining = 1'b0;
                if (!draining)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else if (pending_chars.size() > 0)
                    begin
                        item = pending_chars[0];
                        if (item.hold)
                        begin
                            void'(pending_chars.pop_front());
                            draining = 1'b1;
                        end
                        else if (item.gap > 0)
                        begin
                            gap_left             = item.gap - 1;
                            pending_chars[0].gap = 0;
                        end
                        else
                        begin
                            void'(pending_chars.pop_front());
                            next_valid = 1'b1;
                            text_byte <= item.ch;
                        end
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // Output monitor: checks each returned number and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        parsed_number_t want;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_left  = 0;
            steady_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_numbers.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, mantissa, fraction_digits, digit_seen, overflowed);
                    error_count++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    compare_field("mantissa", want.mant, mantissa);
                    compare_field("fraction_digits", want.frac, fraction_digits);
                    compare_field("digit_seen", want.seen, digit_seen);
                    compare_field("overflowed", want.ovf, overflowed);
                    numbers_checked++;
                    if (want.ovf)
                        saturated_numbers++;
                    if (want.frac != 0)
                        fraction_numbers++;
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (steady_left > 0)
                    steady_left--;
                else if ($urandom_range(0, 19) == 0)
                    steady_left = $urandom_range(20, 80);
                else
                    stall_left = idle_length();
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        text_item_t  hold_item;
        int unsigned line_count;
        int unsigned int_digits;
        bit          steady;

        hold_item.ch   = CHAR_NUL;
        hold_item.gap  = 0;
        hold_item.hold = 1'b1;

        // Directed lines: an empty line, a separator and a top-bit byte ahead
        // of the digits, too many fraction digits, the first value that
        // saturates, and a number cut short by some other character.
        queue_char(CHAR_NUL, 1'b0);
        queue_char(CHAR_DOT, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_text("9");
        queue_char(CHAR_NUL, 1'b0);
        queue_text("5,1234567");
        queue_char(CHAR_NUL, 1'b0);
        queue_text("4294967296");
        queue_char(CHAR_NUL, 1'b0);
        queue_text("7a3");
        queue_char(CHAR_NUL, 1'b0);

        // Random lines, mostly well formed, with some pure noise.
        line_count = 0;
        while (pending_chars.size() < 440)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (line_count % 25 == 12)
                pending_chars.push_back(hold_item);
            if ($urandom_range(0, 99) < 80)
            begin
                repeat ($urandom_range(0, 3))
                    queue_char(random_non_digit(), steady);
                int_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                         : $urandom_range(1, 5);
                repeat (int_digits)
                    queue_char(random_digit(), steady);
                if ($urandom_range(0, 2) != 0)
                begin
                    queue_char($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA, steady);
                    repeat ($urandom_range(0, 8))
                        queue_char(random_digit(), steady);
                end
                if ($urandom_range(0, 1))
                begin
                    queue_char(random_non_digit(), steady);
                    repeat ($urandom_range(0, 3))
                        queue_char(TEXT_W'($urandom_range(1, 255)), steady);
                end
            end
            else
            begin
                repeat ($urandom_range(0, 6))
                    queue_char(TEXT_W'($urandom_range(1, 255)), steady);
            end
            queue_char(CHAR_NUL, steady);
            line_count++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid || draining
               || expected_numbers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters over %0d random lines plus directed cases.",
                 bytes_accepted, line_count);
        $display("Checked %0d numbers: %0d saturated, %0d with fraction digits.",
                 numbers_checked, saturated_numbers, fraction_numbers);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("Timeout with %0d numbers outstanding", expected_numbers.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dtnp_pkg.sv
rtl/dtnp_digit_acc.sv
rtl/decimal_text_number_parser_top.sv
tb/decimal_text_number_parser_top_test.sv
